// ===== rtl/core/casc_pkg.sv =====
// casc_pkg: shared types, codes and helpers for the clock and alarm setting controller
// no dependencies; used by every module under rtl/core
package casc_pkg;

    localparam int HmsW       = 17;
    localparam int BlinkW     = 13;
    localparam int AlertW     = 14;
    localparam int LedHalfW   = 12;
    localparam int PhaseW     = 13;
    localparam int CfgDataW   = 14;
    localparam int CfgIndexW  = 2;
    localparam int RemStepsW  = 4;

    localparam logic [5:0] HOUR_MAX   = 6'd23;
    localparam logic [5:0] MINSEC_MAX = 6'd59;

    localparam logic [RemStepsW-1:0] REM_LAST_STEP = RemStepsW'(AlertW - 1);

    // actions
    localparam logic [2:0] ACT_TICK        = 3'd0;
    localparam logic [2:0] ACT_CLOCK_SET   = 3'd1;
    localparam logic [2:0] ACT_ALARM_SET   = 3'd2;
    localparam logic [2:0] ACT_PLUS        = 3'd3;
    localparam logic [2:0] ACT_MINUS_PRESS = 3'd4;
    localparam logic [2:0] ACT_MINUS_REL   = 3'd5;

    // edit fields, also the edit mode counter values
    localparam logic [1:0] FIELD_NONE   = 2'd0;
    localparam logic [1:0] FIELD_HOUR   = 2'd1;
    localparam logic [1:0] FIELD_MINUTE = 2'd2;
    localparam logic [1:0] FIELD_SECOND = 2'd3;

    // setting modes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_CLOCK  = 2'd1;
    localparam logic [1:0] MODE_ALARM  = 2'd2;

    // register indexes
    localparam logic [CfgIndexW-1:0] CFG_BLINK_PERIOD  = 2'd0;
    localparam logic [CfgIndexW-1:0] CFG_BLINK_VISIBLE = 2'd1;
    localparam logic [CfgIndexW-1:0] CFG_ALERT_TICKS   = 2'd2;
    localparam logic [CfgIndexW-1:0] CFG_LED_HALF      = 2'd3;

    localparam logic [BlinkW-1:0]   BLINK_PERIOD_RST  = 13'd2000;
    localparam logic [BlinkW-1:0]   BLINK_VISIBLE_RST = 13'd1000;
    localparam logic [AlertW-1:0]   ALERT_TICKS_RST   = 14'd5000;
    localparam logic [LedHalfW-1:0] LED_HALF_RST      = 12'd200;

    typedef struct packed {
        logic [BlinkW-1:0]   blink_period_ticks;
        logic [BlinkW-1:0]   blink_visible_ticks;
        logic [AlertW-1:0]   alert_ticks;
        logic [LedHalfW-1:0] led_half_ticks;
    } cfg_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [4:0]        rtc_hour;
        logic [5:0]        rtc_minute;
        logic [5:0]        rtc_second;
        logic signed [7:0] temperature_sample;
    } item_t;

    typedef struct packed {
        logic [1:0]        setting_mode;
        logic [1:0]        edit_field;
        logic [4:0]        shown_hour;
        logic [5:0]        shown_minute;
        logic [5:0]        shown_second;
        logic              field_blanked;
        logic              show_temperature;
        logic signed [7:0] shown_temperature;
        logic              led_on;
        logic              rtc_write;
    } result_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PhaseW-1:0] rem;
    } rem_status_t;

    // saturating step of one field of a packed h:m:s word
    function automatic logic [HmsW-1:0] step_part(input logic [HmsW-1:0] t,
                                                  input logic [1:0] part,
                                                  input logic up);
        logic [5:0] lim;
        logic [5:0] v;
        logic [5:0] nv;
        logic [6:0] inc;
        logic [HmsW-1:0] r;
        lim = (part == FIELD_HOUR) ? HOUR_MAX : MINSEC_MAX;
        case (part)
            FIELD_HOUR:   v = {1'b0, t[16:12]};
            FIELD_MINUTE: v = t[11:6];
            default:      v = t[5:0];
        endcase
        inc = {1'b0, v} + 7'd1;
        if (up) begin
            nv = (inc >= {1'b0, lim}) ? lim : inc[5:0];
        end else if (v == 6'd0) begin
            nv = 6'd0;
        end else begin
            nv = ((v - 6'd1) >= lim) ? lim : (v - 6'd1);
        end
        r = t;
        case (part)
            FIELD_HOUR:   r[16:12] = nv[4:0];
            FIELD_MINUTE: r[11:6]  = nv;
            default:      r[5:0]   = nv;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/casc_rem_div.sv =====
// casc_rem_div: bit-serial remainder of the alert count by the led blink period
// depends on casc_pkg; one quotient bit per cycle, restartable
module casc_rem_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [casc_pkg::AlertW-1:0]   dividend,
    input  logic [casc_pkg::PhaseW-1:0]   divisor,
    output casc_pkg::rem_status_t         status
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [casc_pkg::RemStepsW-1:0]  cnt_reg, cnt_next;
    logic [casc_pkg::AlertW-1:0]     num_reg, num_next;
    logic [casc_pkg::PhaseW-1:0]     den_reg, den_next;
    logic [casc_pkg::PhaseW-1:0]     rem_reg, rem_next;
    logic [casc_pkg::AlertW-1:0]     trial;
    logic [casc_pkg::AlertW-1:0]     den_ext;

    assign trial   = {rem_reg, num_reg[casc_pkg::AlertW-1]};
    assign den_ext = {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            num_next = {num_reg[casc_pkg::AlertW-2:0], 1'b0};
            if (trial >= den_ext) begin
                rem_next = casc_pkg::PhaseW'(trial - den_ext);
            end else begin
                rem_next = trial[casc_pkg::PhaseW-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == casc_pkg::REM_LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign status.rem  = rem_reg;

endmodule

// ===== rtl/core/casc_core.sv =====
// casc_core: clock/alarm setting state and the single-pass next-state and result logic
// depends on casc_pkg and casc_rem_div
module casc_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  casc_pkg::item_t      item,
    input  casc_pkg::cfg_t       cfg,
    input  logic                 led_cfg_written,
    output casc_pkg::result_t    result,
    output logic                 busy
);

    logic [1:0]                    clock_mode_reg, clock_mode_next;
    logic [1:0]                    alarm_mode_reg, alarm_mode_next;
    logic [casc_pkg::HmsW-1:0]     clock_hms_reg, clock_hms_next;
    logic [casc_pkg::HmsW-1:0]     alarm_hms_reg, alarm_hms_next;
    logic [casc_pkg::HmsW-1:0]     edit_hms_reg, edit_hms_next;
    logic                          alarm_valid_reg, alarm_valid_next;
    logic [casc_pkg::BlinkW-1:0]   blink_reg, blink_next;
    logic                          alert_reg, alert_next;
    logic [casc_pkg::AlertW-1:0]   alert_cnt_reg, alert_cnt_next;
    logic [casc_pkg::PhaseW-1:0]   phase_reg, phase_next;
    logic                          temp_view_reg, temp_view_next;
    logic signed [7:0]             temp_reg, temp_next;

    logic                          is_key;
    logic                          up;
    logic                          setting;
    logic                          rtc_write;
    logic [casc_pkg::BlinkW-1:0]   blink_inc;
    logic [casc_pkg::AlertW-1:0]   alert_inc;
    logic [casc_pkg::PhaseW-1:0]   phase_inc;
    logic [casc_pkg::LedHalfW-1:0] half;
    logic [casc_pkg::PhaseW-1:0]   period;
    logic [casc_pkg::HmsW-1:0]     shown;
    casc_pkg::rem_status_t         rem_st;

    assign half   = (cfg.led_half_ticks == '0) ? casc_pkg::LedHalfW'(1) : cfg.led_half_ticks;
    assign period = {half, 1'b0};

    casc_rem_div u_rem_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (led_cfg_written),
        .dividend (alert_cnt_reg),
        .divisor  (period),
        .status   (rem_st)
    );

    assign busy = led_cfg_written | rem_st.busy | rem_st.done;

    always_comb begin
        clock_mode_next  = clock_mode_reg;
        alarm_mode_next  = alarm_mode_reg;
        clock_hms_next   = clock_hms_reg;
        alarm_hms_next   = alarm_hms_reg;
        edit_hms_next    = edit_hms_reg;
        alarm_valid_next = alarm_valid_reg;
        blink_next       = blink_reg;
        alert_next       = alert_reg;
        alert_cnt_next   = alert_cnt_reg;
        phase_next       = phase_reg;
        temp_view_next   = temp_view_reg;
        temp_next        = temp_reg;
        rtc_write        = 1'b0;
        blink_inc        = '0;
        alert_inc        = '0;
        phase_inc        = '0;
        up               = (item.action == casc_pkg::ACT_PLUS);
        is_key           = (item.action == casc_pkg::ACT_CLOCK_SET)
                        || (item.action == casc_pkg::ACT_ALARM_SET)
                        || (item.action == casc_pkg::ACT_PLUS)
                        || (item.action == casc_pkg::ACT_MINUS_PRESS);

        if (is_key) begin
            alert_next     = 1'b0;
            alert_cnt_next = '0;
            phase_next     = '0;
            temp_view_next = 1'b0;
        end

        case (item.action) inside
            casc_pkg::ACT_CLOCK_SET: begin
                if (alarm_mode_reg == casc_pkg::FIELD_NONE) begin
                    clock_mode_next = clock_mode_reg + 2'd1;
                    rtc_write = (clock_mode_reg == casc_pkg::FIELD_SECOND);
                end
            end
            casc_pkg::ACT_ALARM_SET: begin
                if (clock_mode_reg == casc_pkg::FIELD_NONE) begin
                    alarm_mode_next = alarm_mode_reg + 2'd1;
                    if (alarm_mode_reg == casc_pkg::FIELD_SECOND) begin
                        alarm_hms_next   = edit_hms_reg;
                        alarm_valid_next = 1'b1;
                    end else if (alarm_mode_reg == casc_pkg::FIELD_NONE) begin
                        edit_hms_next = clock_hms_reg;
                    end
                end
            end
            casc_pkg::ACT_PLUS, casc_pkg::ACT_MINUS_PRESS: begin
                if (clock_mode_reg != casc_pkg::FIELD_NONE) begin
                    clock_hms_next = casc_pkg::step_part(clock_hms_reg, clock_mode_reg, up);
                end else if (alarm_mode_reg != casc_pkg::FIELD_NONE) begin
                    edit_hms_next = casc_pkg::step_part(edit_hms_reg, alarm_mode_reg, up);
                end else if (!up) begin
                    temp_next      = item.temperature_sample;
                    temp_view_next = 1'b1;
                end
            end
            casc_pkg::ACT_MINUS_REL: begin
                temp_view_next = 1'b0;
            end
            default: begin
            end
        endcase

        setting = (clock_mode_next != casc_pkg::FIELD_NONE)
               || (alarm_mode_next != casc_pkg::FIELD_NONE);

        if (!setting && !rtc_write) begin
            clock_hms_next = {item.rtc_hour, item.rtc_minute, item.rtc_second};
        end

        if (alarm_valid_next && (clock_hms_next == alarm_hms_next)) begin
            alert_next     = 1'b1;
            alert_cnt_next = '0;
            phase_next     = '0;
        end

        if (item.action == casc_pkg::ACT_TICK) begin
            if (setting) begin
                blink_inc  = blink_reg + 1'b1;
                blink_next = (blink_inc >= cfg.blink_period_ticks) ? '0 : blink_inc;
            end
            if (alert_next) begin
                alert_inc = alert_cnt_next + 1'b1;
                phase_inc = phase_next + 1'b1;
                if (alert_inc >= cfg.alert_ticks) begin
                    alert_cnt_next = '0;
                    alert_next     = 1'b0;
                end else begin
                    alert_cnt_next = alert_inc;
                end
                if (alert_cnt_next == '0 || phase_inc == period) begin
                    phase_next = '0;
                end else begin
                    phase_next = phase_inc;
                end
            end
        end

        shown = (alarm_mode_next != casc_pkg::FIELD_NONE) ? edit_hms_next : clock_hms_next;

        if (clock_mode_next != casc_pkg::FIELD_NONE) begin
            result.setting_mode = casc_pkg::MODE_CLOCK;
            result.edit_field   = clock_mode_next;
        end else if (alarm_mode_next != casc_pkg::FIELD_NONE) begin
            result.setting_mode = casc_pkg::MODE_ALARM;
            result.edit_field   = alarm_mode_next;
        end else begin
            result.setting_mode = casc_pkg::MODE_NORMAL;
            result.edit_field   = casc_pkg::FIELD_NONE;
        end
        result.shown_hour        = shown[16:12];
        result.shown_minute      = shown[11:6];
        result.shown_second      = shown[5:0];
        result.field_blanked     = setting && (blink_next > cfg.blink_visible_ticks);
        result.show_temperature  = temp_view_next && !setting;
        result.shown_temperature = temp_next;
        result.led_on            = alert_next && (phase_next >= {1'b0, half});
        result.rtc_write         = rtc_write;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_mode_reg  <= casc_pkg::FIELD_NONE;
            alarm_mode_reg  <= casc_pkg::FIELD_NONE;
            clock_hms_reg   <= '0;
            alarm_hms_reg   <= '0;
            edit_hms_reg    <= '0;
            alarm_valid_reg <= 1'b0;
            blink_reg       <= '0;
            alert_reg       <= 1'b0;
            alert_cnt_reg   <= '0;
            phase_reg       <= '0;
            temp_view_reg   <= 1'b0;
            temp_reg        <= '0;
        end else if (step) begin
            clock_mode_reg  <= clock_mode_next;
            alarm_mode_reg  <= alarm_mode_next;
            clock_hms_reg   <= clock_hms_next;
            alarm_hms_reg   <= alarm_hms_next;
            edit_hms_reg    <= edit_hms_next;
            alarm_valid_reg <= alarm_valid_next;
            blink_reg       <= blink_next;
            alert_reg       <= alert_next;
            alert_cnt_reg   <= alert_cnt_next;
            phase_reg       <= phase_next;
            temp_view_reg   <= temp_view_next;
            temp_reg        <= temp_next;
        end else if (rem_st.done) begin
            phase_reg <= rem_st.rem;
        end
    end

    // led phase tracks alert count modulo the blink period
    assert property (@(posedge aclk) disable iff (!aresetn)
        !busy |-> (phase_reg < period))
        else $error("led phase out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !alert_reg |-> (alert_cnt_reg == '0 && phase_reg == '0))
        else $error("alert counter running while reminder inactive");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(clock_mode_reg != casc_pkg::FIELD_NONE && alarm_mode_reg != casc_pkg::FIELD_NONE))
        else $error("clock and alarm setting active together");

endmodule

// ===== rtl/core/clock_alarm_setting_controller_top.sv =====
// clock_alarm_setting_controller_top: ports, config registers, input and result registers
// depends on casc_pkg and casc_core
//
//   channel | direction | handshake            | payload
//   s_      | in        | s_valid / s_ready    | action, rtc time, temperature sample
//   m_      | out       | m_valid / m_ready    | mode, field, shown time, flags, rtc_write
//   cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one item per cycle sustained while m_ready is high and the core is not busy
// each item passes an input register, one pass through the core logic, a result register
// a write to led_half_ticks restarts a bit-serial remainder of the alert count,
// s_ready stays low after that write until the remainder is done
// s_ready follows m_ready when both stages are full and the core is not busy; aresetn is synchronous, active low
module clock_alarm_setting_controller_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [2:0]                            s_action,
    input  logic [4:0]                            s_rtc_hour,
    input  logic [5:0]                            s_rtc_minute,
    input  logic [5:0]                            s_rtc_second,
    input  logic signed [7:0]                     s_temperature_sample,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [1:0]                            m_setting_mode,
    output logic [1:0]                            m_edit_field,
    output logic [4:0]                            m_shown_hour,
    output logic [5:0]                            m_shown_minute,
    output logic [5:0]                            m_shown_second,
    output logic                                  m_field_blanked,
    output logic                                  m_show_temperature,
    output logic signed [7:0]                     m_shown_temperature,
    output logic                                  m_led_on,
    output logic                                  m_rtc_write,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [casc_pkg::CfgIndexW-1:0]        cfg_index,
    input  logic [casc_pkg::CfgDataW-1:0]         cfg_data
);

    casc_pkg::cfg_t    cfg_reg;
    casc_pkg::item_t   in_item_reg;
    casc_pkg::result_t res_reg;
    casc_pkg::result_t core_res;
    logic              in_valid_reg;
    logic              m_valid_reg;
    logic              advance;
    logic              core_busy;
    logic              cfg_wr;
    logic              led_cfg_written;
    logic              led_wr_reg;

    assign cfg_ready       = 1'b1;
    assign cfg_wr          = cfg_valid && cfg_ready;
    assign led_cfg_written = cfg_wr && (cfg_index == casc_pkg::CFG_LED_HALF);

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = (!in_valid_reg || advance) && !core_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blink_period_ticks  <= casc_pkg::BLINK_PERIOD_RST;
            cfg_reg.blink_visible_ticks <= casc_pkg::BLINK_VISIBLE_RST;
            cfg_reg.alert_ticks         <= casc_pkg::ALERT_TICKS_RST;
            cfg_reg.led_half_ticks      <= casc_pkg::LED_HALF_RST;
            led_wr_reg                  <= 1'b0;
        end else begin
            led_wr_reg <= led_cfg_written;
            if (cfg_wr) begin
                unique case (cfg_index)
                    casc_pkg::CFG_BLINK_PERIOD:
                        cfg_reg.blink_period_ticks  <= cfg_data[casc_pkg::BlinkW-1:0];
                    casc_pkg::CFG_BLINK_VISIBLE:
                        cfg_reg.blink_visible_ticks <= cfg_data[casc_pkg::BlinkW-1:0];
                    casc_pkg::CFG_ALERT_TICKS:
                        cfg_reg.alert_ticks         <= cfg_data[casc_pkg::AlertW-1:0];
                    casc_pkg::CFG_LED_HALF:
                        cfg_reg.led_half_ticks      <= cfg_data[casc_pkg::LedHalfW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (s_valid && s_ready) begin
            in_item_reg.action             <= s_action;
            in_item_reg.rtc_hour           <= s_rtc_hour;
            in_item_reg.rtc_minute         <= s_rtc_minute;
            in_item_reg.rtc_second         <= s_rtc_second;
            in_item_reg.temperature_sample <= s_temperature_sample;
        end
        if (advance) begin
            res_reg <= core_res;
        end
    end

    casc_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (advance),
        .item            (in_item_reg),
        .cfg             (cfg_reg),
        .led_cfg_written (led_wr_reg),
        .result          (core_res),
        .busy            (core_busy)
    );

    assign m_valid             = m_valid_reg;
    assign m_setting_mode      = res_reg.setting_mode;
    assign m_edit_field        = res_reg.edit_field;
    assign m_shown_hour        = res_reg.shown_hour;
    assign m_shown_minute      = res_reg.shown_minute;
    assign m_shown_second      = res_reg.shown_second;
    assign m_field_blanked     = res_reg.field_blanked;
    assign m_show_temperature  = res_reg.show_temperature;
    assign m_shown_temperature = res_reg.shown_temperature;
    assign m_led_on            = res_reg.led_on;
    assign m_rtc_write         = res_reg.rtc_write;

    // an rtc write item always leaves setting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.rtc_write) |->
            (res_reg.setting_mode == casc_pkg::MODE_NORMAL
             && res_reg.edit_field == casc_pkg::FIELD_NONE))
        else $error("rtc write while still setting");

endmodule
